// ===== design/papc_pkg.sv =====
// ============================================================================
// papc_pkg
// Shared types, constants and table functions for the access pattern classifier.
// ============================================================================
package papc_pkg;

    localparam int unsigned ROW_OFFSET_BITS = 32;
    localparam int unsigned LIMIT_BITS      = 7;
    localparam int unsigned OUT_DATA_BITS   = 8;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd100;
    localparam logic [LIMIT_BITS-1:0] ITEMS_MAX   = 7'd127;

    typedef enum logic [2:0] {
        PAT_POINT    = 3'd0,
        PAT_SEQ_INC  = 3'd1,
        PAT_MONO_INC = 3'd2,
        PAT_SEQ_DEC  = 3'd3,
        PAT_MONO_DEC = 3'd4,
        PAT_RANDOM   = 3'd5
    } t_pattern;

    typedef enum logic [2:0] {
        STEP_ZERO      = 3'd0,
        STEP_PLUS_ONE  = 3'd1,
        STEP_POS       = 3'd2,
        STEP_MINUS_ONE = 3'd3,
        STEP_NEG       = 3'd4
    } t_step;

    typedef enum logic [1:0] {
        KIND_POINT      = 2'd0,
        KIND_SEQUENTIAL = 2'd1,
        KIND_MONOTONIC  = 2'd2,
        KIND_RANDOM     = 2'd3
    } t_kind;

    // Result of one classification step, handed from the step unit to the top.
    typedef struct packed {
        t_step    step;
        t_pattern next;
    } t_step_res;

    function automatic t_pattern next_pattern(input t_pattern st, input t_step sp);
        t_pattern r;
        r = PAT_RANDOM;
        case (st)
            PAT_POINT: begin
                case (sp)
                    STEP_ZERO:      r = PAT_POINT;
                    STEP_PLUS_ONE:  r = PAT_SEQ_INC;
                    STEP_POS:       r = PAT_MONO_INC;
                    STEP_MINUS_ONE: r = PAT_SEQ_DEC;
                    STEP_NEG:       r = PAT_MONO_DEC;
                    default:        r = PAT_RANDOM;
                endcase
            end
            PAT_SEQ_INC: begin
                case (sp)
                    STEP_ZERO, STEP_PLUS_ONE: r = PAT_SEQ_INC;
                    STEP_POS:                 r = PAT_MONO_INC;
                    default:                  r = PAT_RANDOM;
                endcase
            end
            PAT_MONO_INC: begin
                case (sp)
                    STEP_ZERO, STEP_PLUS_ONE, STEP_POS: r = PAT_MONO_INC;
                    default:                            r = PAT_RANDOM;
                endcase
            end
            PAT_SEQ_DEC: begin
                case (sp)
                    STEP_ZERO, STEP_MINUS_ONE: r = PAT_SEQ_DEC;
                    STEP_NEG:                  r = PAT_MONO_DEC;
                    default:                   r = PAT_RANDOM;
                endcase
            end
            PAT_MONO_DEC: begin
                case (sp)
                    STEP_ZERO, STEP_MINUS_ONE, STEP_NEG: r = PAT_MONO_DEC;
                    default:                             r = PAT_RANDOM;
                endcase
            end
            default: r = PAT_RANDOM;
        endcase
        return r;
    endfunction

    function automatic t_kind kind_of(input t_pattern st);
        t_kind k;
        case (st)
            PAT_POINT:                 k = KIND_POINT;
            PAT_SEQ_INC, PAT_SEQ_DEC:  k = KIND_SEQUENTIAL;
            PAT_MONO_INC, PAT_MONO_DEC: k = KIND_MONOTONIC;
            default:                   k = KIND_RANDOM;
        endcase
        return k;
    endfunction

endpackage

// ===== design/papc_step.sv =====
// ============================================================================
// papc_step
// Sorts the step between two offsets into five classes and advances the pattern.
// ============================================================================
module papc_step #(
    parameter int unsigned W = 32
) (
    input  logic [W-1:0]           i_prev,
    input  logic [W-1:0]           i_cur,
    input  papc_pkg::t_pattern     i_state,
    output papc_pkg::t_step_res    o_res
);
    import papc_pkg::*;

    logic [W:0] prev_ext;
    logic [W:0] cur_ext;
    t_step      step;

    assign prev_ext = {1'b0, i_prev};
    assign cur_ext  = {1'b0, i_cur};

    // Widened compares so that a step across the top of the range never wraps.
    always_comb begin
        if (cur_ext == prev_ext) begin
            step = STEP_ZERO;
        end else if (cur_ext > prev_ext) begin
            step = (cur_ext == prev_ext + 1'b1) ? STEP_PLUS_ONE : STEP_POS;
        end else begin
            step = (prev_ext == cur_ext + 1'b1) ? STEP_MINUS_ONE : STEP_NEG;
        end
    end

    assign o_res.step = step;
    assign o_res.next = next_pattern(i_state, step);

endmodule

// ===== design/position_access_pattern_classifier.sv =====
// ============================================================================
// position_access_pattern_classifier
// Classifies the access pattern of a list of row offsets, one result per list.
// ============================================================================
// Usage:
// The slave stream carries one row offset per transaction in i_s_tdata, with
// i_s_tlast high on the final offset of a list. The master stream returns one
// transaction per list, carrying the pattern code and its access type.
// The configuration channel writes compare_limit, the number of leading
// offsets of a list that take part; the user must write it only while the
// block is idle, since the block itself does not enforce this.
// An accepted offset lands in an input register, is then classified against
// the previous offset and updates the pattern state; for the final offset of a
// list the result register, which drives o_m_tvalid, is loaded at that edge.
// Throughput: one offset per cycle while no list end waits, set by the single
// subtract-compare and table step between input and state/result registers.
// Reset (synchronous, active low) empties both registers, clears the pattern
// state and item count, and restores compare_limit to 100.
// Stall: when the receiver holds i_m_tready low, offsets that do not end a
// list keep flowing; a list end waits in the input register until the result
// register frees up, and o_s_tready stays low for as long as it waits.
// ============================================================================
module position_access_pattern_classifier #(
    parameter int unsigned OFFSET_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Slave stream: tdata[31:0] = row_offset; tlast = list_end.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [papc_pkg::ROW_OFFSET_BITS-1:0]   i_s_tdata,
    input  logic                                   i_s_tlast,
    // Master stream: tdata[2:0] = pattern_code, [4:3] = kind_code, [7:5] = 0.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [papc_pkg::OUT_DATA_BITS-1:0]     o_m_tdata,
    // Configuration channel: compare_limit.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [papc_pkg::LIMIT_BITS-1:0]        i_cfg_data
);
    import papc_pkg::*;

    // Only the low OFFSET_BITS bits of an offset count, and never more than
    // the 32 bits that the port carries.
    localparam int unsigned USED_BITS =
        (OFFSET_BITS < ROW_OFFSET_BITS) ? OFFSET_BITS : ROW_OFFSET_BITS;

    // Configuration register.
    logic [LIMIT_BITS-1:0] r_compare_limit;

    // Input register.
    logic                 r_in_valid;
    logic [USED_BITS-1:0] r_in_offset;
    logic                 r_in_last;

    // Per-list state.
    logic [USED_BITS-1:0]  r_prev;
    logic [USED_BITS-1:0]  n_prev;
    t_pattern              r_pattern;
    t_pattern              n_pattern;
    logic [LIMIT_BITS-1:0] r_items_seen;
    logic [LIMIT_BITS-1:0] n_items_seen;

    // Result register.
    logic     r_out_valid;
    t_pattern r_out_pattern;
    t_kind    r_out_kind;

    logic      advance;
    logic      take;
    t_pattern  upd_pattern;
    t_step_res step_res;

    // The input register moves on when it holds an offset and either that
    // offset produces no result or the result register can take one now.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign take       = (r_items_seen < r_compare_limit);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compare_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compare_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_offset <= i_s_tdata[USED_BITS-1:0];
            r_in_last   <= i_s_tlast;
        end
    end

    papc_step #(
        .W (USED_BITS)
    ) u_step (
        .i_prev  (r_prev),
        .i_cur   (r_in_offset),
        .i_state (r_pattern),
        .o_res   (step_res)
    );

    // The first offset of a list only seeds the previous offset; later ones
    // within the compare limit step the pattern machine. The list end resets
    // the pattern and count, while the previous offset is simply overwritten
    // by the next list's first offset.
    always_comb begin
        upd_pattern  = r_pattern;
        n_prev       = r_prev;
        n_pattern    = r_pattern;
        n_items_seen = r_items_seen;
        if (advance) begin
            if (take) begin
                if (r_items_seen != '0) begin
                    upd_pattern = step_res.next;
                end
                n_prev = r_in_offset;
            end
            if (r_in_last) begin
                n_pattern    = PAT_POINT;
                n_items_seen = '0;
            end else begin
                n_pattern = upd_pattern;
                if (r_items_seen != ITEMS_MAX) begin
                    n_items_seen = r_items_seen + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= PAT_POINT;
            r_items_seen <= '0;
        end else begin
            r_pattern    <= n_pattern;
            r_items_seen <= n_items_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_pattern <= upd_pattern;
            r_out_kind    <= kind_of(upd_pattern);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_kind, r_out_pattern};

    // A list end always leaves the machine ready for a fresh list.
    a_list_end_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_pattern == PAT_POINT && r_items_seen == '0)
        else $error("list end did not clear the pattern state");

    // Random absorbs for the rest of the list.
    a_random_absorbs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pattern == PAT_RANDOM && !(advance && r_in_last) |=> r_pattern == PAT_RANDOM)
        else $error("pattern left random before the list ended");

    // Offsets beyond the compare limit must not touch the previous offset.
    a_limit_freezes_prev : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !take |=> $stable(r_prev))
        else $error("offset beyond compare limit changed the previous offset");

    // A pending result is never overwritten or dropped while stalled.
    a_result_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid && $stable(r_out_pattern))
        else $error("pending result lost under back-pressure");

    // The access type always matches the pattern it travels with.
    a_kind_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_kind == kind_of(r_out_pattern))
        else $error("access type does not match pattern");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the access pattern classifier: streams lists of row
// offsets with random gaps and back-pressure, predicts the pattern and access
// type of every list, and compares each returned transaction against it.
// ============================================================================
module tb_top;

    import papc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned SETTLE       = 4;

    // Shapes for randomly built lists. Each shape aims at one pattern, noise
    // aims at random.
    typedef enum int unsigned {
        GEN_SEQ_INC,
        GEN_MONO_INC,
        GEN_SEQ_DEC,
        GEN_MONO_DEC,
        GEN_FLAT,
        GEN_NOISE
    } t_gen;

    // Predicts the classifier. It keeps its own copy of compare_limit and of
    // the list state, and queues one expected pattern per list.
    class pattern_scoreboard;

        typedef struct {
            t_pattern pat;
            t_kind    kind;
        } t_expected_result;

        t_expected_result expected[$];
        logic [LIMIT_BITS-1:0]      limit;
        logic [ROW_OFFSET_BITS-1:0] prev;
        t_pattern                   pat;
        logic [LIMIT_BITS-1:0]      seen;
        int                         errors;

        function new();
            limit  = LIMIT_RESET;
            prev   = '0;
            pat    = PAT_POINT;
            seen   = '0;
            errors = 0;
        endfunction

        function void set_limit(logic [LIMIT_BITS-1:0] value);
            limit = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function t_step step_class(logic [ROW_OFFSET_BITS-1:0] from,
                                   logic [ROW_OFFSET_BITS-1:0] to);
            t_step sp;
            if (to == from) begin
                sp = STEP_ZERO;
            end else if (to > from) begin
                sp = (to - from == 1) ? STEP_PLUS_ONE : STEP_POS;
            end else begin
                sp = (from - to == 1) ? STEP_MINUS_ONE : STEP_NEG;
            end
            return sp;
        endfunction

        // A zero step never changes the pattern. A step in the direction of
        // the pattern keeps it, or widens sequential to monotonic; a step
        // against it falls to random, which never leaves.
        function t_pattern advance_pattern(t_pattern cur, t_step sp);
            t_pattern nxt;
            nxt = cur;
            if (cur == PAT_POINT) begin
                case (sp)
                    STEP_PLUS_ONE:  nxt = PAT_SEQ_INC;
                    STEP_POS:       nxt = PAT_MONO_INC;
                    STEP_MINUS_ONE: nxt = PAT_SEQ_DEC;
                    STEP_NEG:       nxt = PAT_MONO_DEC;
                    default:        nxt = PAT_POINT;
                endcase
            end else if (cur == PAT_SEQ_INC || cur == PAT_MONO_INC) begin
                if (sp == STEP_POS) begin
                    nxt = PAT_MONO_INC;
                end else if (sp == STEP_MINUS_ONE || sp == STEP_NEG) begin
                    nxt = PAT_RANDOM;
                end
            end else if (cur == PAT_SEQ_DEC || cur == PAT_MONO_DEC) begin
                if (sp == STEP_NEG) begin
                    nxt = PAT_MONO_DEC;
                end else if (sp == STEP_PLUS_ONE || sp == STEP_POS) begin
                    nxt = PAT_RANDOM;
                end
            end else begin
                nxt = PAT_RANDOM;
            end
            return nxt;
        endfunction

        function t_kind access_kind(t_pattern p);
            t_kind k;
            case (p)
                PAT_POINT:                  k = KIND_POINT;
                PAT_SEQ_INC, PAT_SEQ_DEC:   k = KIND_SEQUENTIAL;
                PAT_MONO_INC, PAT_MONO_DEC: k = KIND_MONOTONIC;
                default:                    k = KIND_RANDOM;
            endcase
            return k;
        endfunction

        // Called for every accepted offset transaction.
        function void note_offset(logic [ROW_OFFSET_BITS-1:0] offset, bit list_end);
            t_expected_result res;
            if (seen < limit) begin
                if (seen != 0) begin
                    pat = advance_pattern(pat, step_class(prev, offset));
                end
                prev = offset;
            end
            if (seen != ITEMS_MAX) begin
                seen = seen + 1'b1;
            end
            if (list_end) begin
                res.pat  = pat;
                res.kind = access_kind(pat);
                expected.push_back(res);
                pat  = PAT_POINT;
                seen = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Called for every accepted result transaction.
        task check_result(logic [OUT_DATA_BITS-1:0] data);
            t_expected_result res;
            if (expected.size() == 0) begin
                report($sformatf("result 0x%h with no list pending", data));
                return;
            end
            res = expected.pop_front();
            if (data[2:0] !== res.pat) begin
                report($sformatf("pattern %0d, predicted %0d", data[2:0], res.pat));
            end
            if (data[4:3] !== res.kind) begin
                report($sformatf("access type %0d, predicted %0d", data[4:3], res.kind));
            end
            if (data[7:5] !== 3'b000) begin
                report($sformatf("padding bits 0x%h not zero", data[7:5]));
            end
        endtask

    endclass

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [ROW_OFFSET_BITS-1:0] i_s_tdata  = '0;   // [31:0] row_offset
    logic                       i_s_tlast  = 1'b0; // list_end
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]   o_m_tdata;         // [2:0] pattern_code, [4:3] kind_code
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [LIMIT_BITS-1:0]      i_cfg_data  = '0;  // compare_limit

    pattern_scoreboard sb = new();

    bit          quiet       = 1'b0; // when set, no random gaps or receiver waits
    int unsigned rx_hold     = 0;    // long receiver hold-off, in cycles
    int unsigned rx_wait     = 0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    logic [ROW_OFFSET_BITS-1:0] list_buf[$];

    position_access_pattern_classifier uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: checks every result transaction, then idles a random number
    // of cycles. A requested long hold-off takes priority and is counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
                rx_wait = quiet ? 0 : $urandom_range(0, 7);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offers one offset after a random gap and returns at the edge where the
    // transaction is accepted. tvalid is left high so that a following call
    // in the same step can continue the burst without a bubble.
    task automatic send_offset(input logic [ROW_OFFSET_BITS-1:0] offset, input bit list_end);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= offset;
        i_s_tlast  <= list_end;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_offset(offset, list_end);
        items_sent++;
    endtask

    // Sends the buffered offsets as one list, the last one ending it.
    task automatic send_buffered();
        for (int i = 0; i < list_buf.size(); i++) begin
            send_offset(list_buf[i], i == list_buf.size() - 1);
        end
        list_buf.delete();
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // compare_limit is written only while the block is idle.
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    function automatic logic [ROW_OFFSET_BITS-1:0] next_offset(
        input t_gen                       shape,
        input logic [ROW_OFFSET_BITS-1:0] prev
    );
        logic [ROW_OFFSET_BITS-1:0] jump;
        logic [ROW_OFFSET_BITS-1:0] nxt;
        jump = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(2, 1000);
        case (shape)
            GEN_SEQ_INC:  nxt = ($urandom_range(0, 7) == 0) ? prev : prev + 1;
            GEN_SEQ_DEC:  nxt = ($urandom_range(0, 7) == 0) ? prev : prev - 1;
            GEN_MONO_INC: begin
                case ($urandom_range(0, 3))
                    0:       nxt = prev;
                    1:       nxt = prev + 1;
                    default: nxt = prev + jump;
                endcase
            end
            GEN_MONO_DEC: begin
                case ($urandom_range(0, 3))
                    0:       nxt = prev;
                    1:       nxt = prev - 1;
                    default: nxt = prev - jump;
                endcase
            end
            GEN_FLAT:     nxt = prev;
            default:      nxt = $urandom;
        endcase
        return nxt;
    endfunction

    // Mostly short, well-formed lists; some long ones that run past the
    // compare limit and the item counter, and some broken by a noise step.
    task automatic send_random_list();
        int unsigned r;
        int unsigned len;
        int unsigned brk;
        t_gen        shape;
        logic [ROW_OFFSET_BITS-1:0] offset;
        r = $urandom_range(0, 99);
        if (r < 88) begin
            len = $urandom_range(1, 12);
        end else if (r < 98) begin
            len = $urandom_range(13, 40);
        end else begin
            len = $urandom_range(120, 150);
        end
        shape = t_gen'($urandom_range(0, 5));
        brk   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
        case ($urandom_range(0, 3))
            0:       offset = '0;
            1:       offset = '1;
            default: offset = $urandom;
        endcase
        for (int i = 0; i < len; i++) begin
            if (i != 0) begin
                offset = next_offset((i == brk) ? GEN_NOISE : shape, offset);
            end
            send_offset(offset, i == len - 1);
        end
    endtask

    task automatic run_lists(input int unsigned n_items);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            send_random_list();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lists under the reset compare limit.
        list_buf = '{32'd0};                                    // single offset
        send_buffered();
        list_buf = '{32'd5, 32'd6, 32'd6, 32'd7};               // +1 with a zero step
        send_buffered();
        list_buf = '{32'd10, 32'd20, 32'd21, 32'd21};           // jumps straight to monotonic
        send_buffered();
        list_buf = '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFE}; // -1 at the top
        send_buffered();
        list_buf = '{32'd100, 32'd40, 32'd39};                  // monotonic decrease
        send_buffered();
        list_buf = '{32'd0, 32'hFFFFFFFF, 32'd0, 32'd1};        // random, and it stays
        send_buffered();
        list_buf = '{32'd3, 32'd2, 32'd3};                      // reversal from -1
        send_buffered();

        // No offset takes part, then only the first one: both give point.
        write_limit('0);
        list_buf = '{32'd1, 32'd2};
        send_buffered();
        write_limit(7'd1);
        list_buf = '{32'd1, 32'd2};
        send_buffered();
        // Two offsets take part; the third one would have made it random.
        write_limit(7'd2);
        list_buf = '{32'd4, 32'd5, 32'd0};
        send_buffered();

        // Largest limit, and the receiver holds off for a long stretch while
        // short lists keep coming, so that list ends back up into the input.
        write_limit(7'd127);
        rx_hold = 300;
        quiet   = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_offset($urandom, 1'b1);
        end
        quiet = 1'b0;
        run_lists(150);

        // Random phases, each under a new compare limit.
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 6))
                0:       write_limit(7'd1);
                1:       write_limit(7'd2);
                2:       write_limit(7'd127);
                3:       write_limit(7'($urandom_range(3, 12)));
                4:       write_limit('0);
                default: write_limit(7'($urandom_range(1, 127)));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            run_lists(120);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
